FILE: rtl/dwsr_pkg.sv
package dwsr_pkg;

  // default sizes of the store
  localparam int unsigned DepthDef     = 64;
  localparam int unsigned DataWidthDef = 32;

  // fixed field widths of the stream payloads
  localparam int unsigned OpW     = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 7;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 3;

  // request operations
  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // end selector
  localparam logic END_HEAD = 1'b0;
  localparam logic END_TAIL = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic shift_up;    // every cell takes its lower neighbour (push at head)
    logic shift_down;  // every cell takes its upper neighbour (pop at head)
    logic load_tail;   // the cell at the fill level takes the key
    logic scan_clear;  // clear match flags before a scan
    logic scan_step;   // one ripple step of flags and read data
    logic compact;     // close the gap left by a removed entry
    logic tail_mode;   // search runs from the tail end
  } cell_ctrl_t;

endpackage

FILE: rtl/deque_with_search_remove.sv
// push, pop at the head: taken in the idle state, result registered in the finishing
// state once the output is free; pop at the tail, read and remove: the scan state first
// ripples match flags and read data along the chain of DEPTH cells, one per cycle, then
// the finishing state registers the result; one request at a time: a new request is
// taken only in the idle state; the next is taken while the result waits at the output
// reset (asynchronous, active low) empties the queue and drops any pending result
module deque_with_search_remove #(
  parameter int unsigned DEPTH      = dwsr_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = dwsr_pkg::DataWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // item_value [31:0], position [37:32], zero [39:38]
  input  logic [dwsr_pkg::InDataW-1:0]   s_axis_tdata,
  // operation [1:0], end_select [2]
  input  logic [dwsr_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_value [31:0], length [38:32], zero [39]
  output logic [dwsr_pkg::OutDataW-1:0]  m_axis_tdata,
  // status [2:0]
  output logic [dwsr_pkg::OutUserW-1:0]  m_axis_tuser
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned StpW = $clog2(DEPTH);
  localparam int unsigned CmpW = (CntW > dwsr_pkg::PosW) ? CntW : dwsr_pkg::PosW;
  localparam logic [CntW-1:0] Full     = CntW'(DEPTH);
  localparam logic [StpW-1:0] LastStep = StpW'(DEPTH - 1);

  dwsr_pkg::state_e     state_q, state_d;
  logic [StpW-1:0]      step_q, step_d;
  logic [CntW-1:0]      count_q, count_d;
  dwsr_pkg::op_e        op_q;
  logic                 end_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [dwsr_pkg::PosW-1:0] pos_q;
  logic [CntW-1:0]      tgt_q, tgt_d;

  logic                           out_valid_q, out_valid_d;
  logic [dwsr_pkg::ValueW-1:0]    out_value_q;
  dwsr_pkg::status_e              out_status_q;
  logic [dwsr_pkg::LenW-1:0]      out_len_q;

  dwsr_pkg::cell_ctrl_t  ctrl;
  logic                  accept;
  logic                  commit;
  logic                  found;
  logic [DATA_WIDTH-1:0] res_value;
  dwsr_pkg::status_e     res_status;

  dwsr_pkg::op_e             in_op;
  logic                      in_end;
  logic [dwsr_pkg::PosW-1:0] in_pos;
  logic                      in_scan;

  logic [DATA_WIDTH-1:0] data_w [DEPTH];
  logic                  flag_w [DEPTH];
  logic [DATA_WIDTH-1:0] rd_w   [DEPTH];

  // request fields
  assign in_op   = dwsr_pkg::op_e'(s_axis_tuser[1:0]);
  assign in_end  = s_axis_tuser[2];
  assign in_pos  = s_axis_tdata[37:32];
  assign in_scan = (in_op == dwsr_pkg::OP_READ) || (in_op == dwsr_pkg::OP_REMOVE) ||
                   ((in_op == dwsr_pkg::OP_POP) && (in_end == dwsr_pkg::END_TAIL));

  assign s_axis_tready = (state_q == dwsr_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // target cell for the read ripple
  always_comb begin
    if (in_op == dwsr_pkg::OP_POP) begin
      tgt_d = count_q - CntW'(1);
    end else if (in_end == dwsr_pkg::END_TAIL) begin
      tgt_d = count_q - CntW'(1) - CntW'(in_pos);
    end else begin
      tgt_d = CntW'(in_pos);
    end
  end

  assign found = end_q ? flag_w[0] : flag_w[DEPTH-1];

  // controller: next state, cell commands and result
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    count_d    = count_q;
    ctrl       = '0;
    commit     = 1'b0;
    res_value  = '0;
    res_status = dwsr_pkg::ST_OK;
    ctrl.tail_mode = end_q;
    case (state_q)
      dwsr_pkg::S_IDLE: begin
        if (accept) begin
          step_d = '0;
          if (in_scan) begin
            ctrl.scan_clear = 1'b1;
            state_d = dwsr_pkg::S_SCAN;
          end else begin
            state_d = dwsr_pkg::S_DONE;
          end
        end
      end
      dwsr_pkg::S_SCAN: begin
        ctrl.scan_step = 1'b1;
        step_d = step_q + StpW'(1);
        if (step_q == LastStep) begin
          state_d = dwsr_pkg::S_DONE;
        end
      end
      dwsr_pkg::S_DONE: begin
        commit = !out_valid_q || m_axis_tready;
        case (op_q)
          dwsr_pkg::OP_PUSH: begin
            if (count_q == Full) begin
              res_status = dwsr_pkg::ST_FULL;
            end else begin
              ctrl.shift_up  = commit && (end_q == dwsr_pkg::END_HEAD);
              ctrl.load_tail = commit && (end_q == dwsr_pkg::END_TAIL);
              if (commit) count_d = count_q + CntW'(1);
            end
          end
          dwsr_pkg::OP_POP: begin
            if (count_q == '0) begin
              res_status = dwsr_pkg::ST_EMPTY;
            end else begin
              res_value = end_q ? rd_w[0] : data_w[0];
              ctrl.shift_down = commit && (end_q == dwsr_pkg::END_HEAD);
              if (commit) count_d = count_q - CntW'(1);
            end
          end
          dwsr_pkg::OP_READ: begin
            if (CmpW'(pos_q) >= CmpW'(count_q)) begin
              res_status = dwsr_pkg::ST_RANGE;
            end else begin
              res_value = rd_w[0];
            end
          end
          default: begin
            if (count_q == '0) begin
              res_status = dwsr_pkg::ST_EMPTY;
            end else if (!found) begin
              res_status = dwsr_pkg::ST_NOTFOUND;
            end else begin
              res_value    = key_q;
              ctrl.compact = commit;
              if (commit) count_d = count_q - CntW'(1);
            end
          end
        endcase
        if (commit) begin
          state_d = dwsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dwsr_pkg::S_IDLE;
      end
    endcase
  end

  // output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dwsr_pkg::S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_op;
      end_q <= in_end;
      key_q <= DATA_WIDTH'(s_axis_tdata[dwsr_pkg::ValueW-1:0]);
      pos_q <= in_pos;
      tgt_q <= tgt_d;
    end
    if (commit) begin
      out_value_q  <= dwsr_pkg::ValueW'(res_value);
      out_status_q <= res_status;
      out_len_q    <= dwsr_pkg::LenW'(count_d);
    end
  end

  // chain of cells, cell 0 holds the head entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data, next_rd;
    logic                  prev_flag, next_flag;

    if (i == 0) begin : g_first
      assign prev_data = key_q;
      assign prev_flag = 1'b0;
    end else begin : g_inner_lo
      assign prev_data = data_w[i-1];
      assign prev_flag = flag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = data_w[i];
      assign next_flag = 1'b0;
      assign next_rd   = '0;
    end else begin : g_inner_hi
      assign next_data = data_w[i+1];
      assign next_flag = flag_w[i+1];
      assign next_rd   = rd_w[i+1];
    end

    dwsr_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CntW),
      .CELL_IDX   (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .tgt_i       (tgt_q),
      .key_i       (key_q),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .prev_flag_i (prev_flag),
      .next_flag_i (next_flag),
      .next_rd_i   (next_rd),
      .data_o      (data_w[i]),
      .flag_o      (flag_w[i]),
      .rd_o        (rd_w[i])
    );
  end

  // result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_len_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTH
  // the fill level never passes the store size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("fill level above store size");

  // the fill level moves by at most one per transaction
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) ||
    (count_q == $past(count_q) - CntW'(1)))
    else $error("fill level jumped");

  // the fill level only changes when a result is committed
  a_count_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> (count_q == $past(count_q)))
    else $error("fill level changed without a result");

  // a new result only appears after the finishing state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dwsr_pkg::S_DONE))
    else $error("result raised outside the finishing state");
`endif

endmodule

FILE: rtl/dwsr_cell.sv
module dwsr_cell #(
  parameter int unsigned DATA_WIDTH = dwsr_pkg::DataWidthDef,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                   clk_i,
  input  dwsr_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [CNT_W-1:0]       tgt_i,
  input  logic [DATA_WIDTH-1:0]  key_i,
  input  logic [DATA_WIDTH-1:0]  prev_data_i,
  input  logic [DATA_WIDTH-1:0]  next_data_i,
  input  logic                   prev_flag_i,
  input  logic                   next_flag_i,
  input  logic [DATA_WIDTH-1:0]  next_rd_i,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic                   flag_o,
  output logic [DATA_WIDTH-1:0]  rd_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  flag_q, flag_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;
  logic                  match;
  logic                  sel;
  logic                  take_next;

  // local match against the key, only for held entries
  assign match = (Idx < count_i) && (data_q == key_i);
  assign sel   = (Idx == tgt_i);

  // head search: this cell is at or past the hit; tail search: no hit above
  assign take_next = ctrl_i.tail_mode ? !next_flag_i : flag_q;

  // next cell contents
  always_comb begin
    data_d = data_q;
    flag_d = flag_q;
    rd_d   = rd_q;
    if (ctrl_i.shift_up) begin
      data_d = prev_data_i;
    end else if (ctrl_i.shift_down) begin
      data_d = next_data_i;
    end else if (ctrl_i.load_tail && (Idx == count_i)) begin
      data_d = key_i;
    end else if (ctrl_i.compact && take_next) begin
      data_d = next_data_i;
    end
    if (ctrl_i.scan_clear) begin
      flag_d = 1'b0;
    end else if (ctrl_i.scan_step) begin
      flag_d = (ctrl_i.tail_mode ? next_flag_i : prev_flag_i) | match;
      rd_d   = sel ? data_q : next_rd_i;
    end
  end

  // cell registers
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    flag_q <= flag_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign flag_o = flag_q;
  assign rd_o   = rd_q;

endmodule
